/* hw/rtl/egpec_pkg.sv */
// Shared types and constants for the electronic gear position error counter.
// Used by the controller, the datapath, the top level and the checker.
package egpec_pkg;

	localparam int POS_W   = 16;
	localparam int LIMIT_W = 16;
	localparam int DEN_W   = 20;
	localparam int REM_W   = DEN_W + 1;
	localparam int DELTA_W = 19;
	localparam int STEP_W  = 17;
	localparam int ERR_W   = 32;
	localparam int ACC_W   = ERR_W + 2;

	localparam int S_TDATA_W = 2 * POS_W;
	localparam int M_TDATA_W = 56;
	localparam int CFG_ADDR_W = 1;

	localparam logic [CFG_ADDR_W-1:0] CFG_WRAP_LIMIT = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_GEAR_DEN   = 1'd1;

	localparam logic [LIMIT_W-1:0] WRAP_LIMIT_RST = 16'd32768;
	localparam logic [DEN_W-1:0]   GEAR_DEN_RST   = 20'd65536;

	localparam logic signed [STEP_W-1:0] STEP_MAX = 17'sd65535;
	localparam logic signed [STEP_W-1:0] STEP_MIN = -17'sd65536;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 34'sd2147483647;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -34'sd2147483648;

	typedef struct packed {
		logic accept;
		logic mul;
		logic load_div;
		logic step;
		logic quo;
		logic acc;
	} egpec_cmd_t;

	typedef struct packed {
		logic out_free;
	} egpec_sts_t;

endpackage

/* hw/rtl/egpec_ctrl.sv */
// Sequencer for one tick: delta, multiply, serial divide, accumulate.
// Depends on egpec_pkg for the command and status structs.
module egpec_ctrl
	import egpec_pkg::*;
#(
	parameter int DIV_STEPS = 36
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  egpec_sts_t sts,
	output egpec_cmd_t cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_QUO  = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             last_step;

	assign last_step = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign s_tready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.load_div = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (last_step) begin
					state_d = ST_QUO;
				end
			end
			ST_QUO: begin
				cmd.quo = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				// Hold here until the output register can take the result.
				if (sts.out_free) begin
					cmd.acc = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load_div) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/egpec_dp.sv */
// Datapath: zero-pass unwrap, gear multiply, restoring divider, saturating error sum,
// configuration registers and the output register. Depends on egpec_pkg.
module egpec_dp
	import egpec_pkg::*;
#(
	parameter int COUNTS_PER_TURN = 65536
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  egpec_cmd_t              cmd,
	output egpec_sts_t              sts,
	input  logic [S_TDATA_W-1:0]    s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_W-1:0]    m_tdata,
	input  logic                    cfg_we,
	input  logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [DEN_W-1:0]        cfg_wdata
);

	localparam int CPT_W = $clog2(COUNTS_PER_TURN + 1);
	localparam int SUM_W = DELTA_W + CPT_W + 1;
	localparam int MAG_W = SUM_W - 1;
	localparam logic signed [CPT_W:0]     CPT_S = (CPT_W + 1)'(COUNTS_PER_TURN);
	localparam logic signed [DELTA_W-1:0] CPT_D = DELTA_W'(COUNTS_PER_TURN);

	// Configuration.
	logic [LIMIT_W-1:0] wrap_limit_q;
	logic [DEN_W-1:0]   gear_den_q;

	// Tick state.
	logic [POS_W-1:0]         last_cmd_q, last_fb_q;
	logic signed [REM_W-1:0]  gear_rem_q;
	logic signed [ERR_W-1:0]  err_acc_q;

	// Work registers.
	logic signed [DELTA_W-1:0] cd_q, fd_q;
	logic signed [SUM_W-1:0]   prod_q;
	logic [DEN_W-1:0]          den_q;
	logic                      neg_q;
	logic [MAG_W-1:0]          mag_q;
	logic [REM_W-1:0]          r_q;
	logic signed [STEP_W-1:0]  step_q;

	// Output register.
	logic                      out_valid_q;
	logic signed [ERR_W-1:0]   out_err_q;
	logic signed [STEP_W-1:0]  out_step_q;
	logic                      out_sat_q;

	logic [POS_W-1:0]          in_cmd, in_fb;
	logic signed [DELTA_W-1:0] cd_d, fd_d;
	logic signed [SUM_W-1:0]   sum_d, sum_neg;
	logic [REM_W-1:0]          r_trial;
	logic                      r_ge;
	logic signed [STEP_W-1:0]  q_pos, q_neg;
	logic signed [ACC_W-1:0]   acc_sum;
	logic signed [ERR_W-1:0]   acc_d;
	logic                      sat_d;

	assign in_cmd = s_tdata[POS_W-1:0];
	assign in_fb  = s_tdata[2*POS_W-1:POS_W];

	function automatic logic signed [DELTA_W-1:0] unwrap(
		input logic [POS_W-1:0]   now_pos,
		input logic [POS_W-1:0]   prev_pos,
		input logic [LIMIT_W-1:0] lim
	);
		logic signed [DELTA_W-1:0] d;
		logic signed [DELTA_W-1:0] l;
		d = signed'(DELTA_W'(now_pos)) - signed'(DELTA_W'(prev_pos));
		l = signed'(DELTA_W'(lim));
		// The lower test sees the result of the upper correction.
		if (d > l) begin
			d = d - CPT_D;
		end
		if (d < -l) begin
			d = d + CPT_D;
		end
		return d;
	endfunction

	assign cd_d = unwrap(in_cmd, last_cmd_q, wrap_limit_q);
	assign fd_d = unwrap(in_fb, last_fb_q, wrap_limit_q);

	assign sum_d   = SUM_W'(gear_rem_q) + prod_q;
	assign sum_neg = -sum_d;

	assign r_trial = {r_q[REM_W-2:0], mag_q[MAG_W-1]};
	assign r_ge    = (r_trial >= {1'b0, den_q});

	// Quotient magnitude to signed step, saturated to the 17-bit range.
	assign q_pos = (mag_q > MAG_W'(STEP_MAX)) ? STEP_MAX : signed'({1'b0, mag_q[STEP_W-2:0]});
	assign q_neg = (mag_q > MAG_W'(65536)) ? STEP_MIN : -signed'(mag_q[STEP_W-1:0]);

	assign acc_sum = ACC_W'(err_acc_q) + ACC_W'(step_q) - ACC_W'(fd_q);

	always_comb begin
		priority if (acc_sum > ACC_MAX) begin
			acc_d = ERR_W'(ACC_MAX);
			sat_d = 1'b1;
		end else if (acc_sum < ACC_MIN) begin
			acc_d = ERR_W'(ACC_MIN);
			sat_d = 1'b1;
		end else begin
			acc_d = acc_sum[ERR_W-1:0];
			sat_d = 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_limit_q <= WRAP_LIMIT_RST;
			gear_den_q <= GEAR_DEN_RST;
			last_cmd_q <= '0;
			last_fb_q <= '0;
			gear_rem_q <= '0;
			err_acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_WRAP_LIMIT: wrap_limit_q <= cfg_wdata[LIMIT_W-1:0];
					CFG_GEAR_DEN:   gear_den_q <= cfg_wdata;
					default:        gear_den_q <= gear_den_q;
				endcase
			end
			if (cmd.accept) begin
				last_cmd_q <= in_cmd;
				last_fb_q <= in_fb;
			end
			if (cmd.quo) begin
				gear_rem_q <= neg_q ? -signed'(r_q) : signed'(r_q);
			end
			if (cmd.acc) begin
				err_acc_q <= acc_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cd_q <= cd_d;
			fd_q <= fd_d;
			// A zero divisor acts as one.
			den_q <= (gear_den_q == '0) ? DEN_W'(1) : gear_den_q;
		end
		if (cmd.mul) begin
			prod_q <= cd_q * CPT_S;
		end
		if (cmd.load_div) begin
			neg_q <= sum_d[SUM_W-1];
			mag_q <= sum_d[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_d[MAG_W-1:0];
			r_q <= '0;
		end else if (cmd.step) begin
			r_q <= r_ge ? (r_trial - {1'b0, den_q}) : r_trial;
			mag_q <= {mag_q[MAG_W-2:0], r_ge};
		end
		if (cmd.quo) begin
			step_q <= neg_q ? q_neg : q_pos;
		end
		if (cmd.acc) begin
			out_err_q <= acc_d;
			out_step_q <= step_q;
			out_sat_q <= sat_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_sat_q, out_step_q, out_err_q};

endmodule

/* hw/rtl/electronic_gear_position_error_counter.sv */
// Top level of the electronic gear position error counter.
// Joins egpec_ctrl and egpec_dp; types and constants come from egpec_pkg.
//
// Channel   Dir  Width  Contents
// s_*       in   32     command_position, feedback_position (one request per tick)
// m_*       out  56     position_error, geared_step, error_saturated
// cfg_*     in   1+20   register index and write data, no read-back
//
// A tick runs through the accept, multiply, sum, divide, quotient and accumulate states.
// The restoring divider in it works one quotient bit per cycle.
// A finished result sits in the output register; a new request is taken while it waits.
// If the previous result is still not taken when the next one is ready, the tick stalls.
// Reset sets both registers to their defaults and clears positions, remainder and error.
module electronic_gear_position_error_counter
	import egpec_pkg::*;
#(
	parameter int COUNTS_PER_TURN = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] command_position, [31:16] feedback_position
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] position_error, [48:32] geared_step,
	                                         // [49] error_saturated, [55:50] zero
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [DEN_W-1:0]      cfg_wdata
);

	localparam int CPT_W = $clog2(COUNTS_PER_TURN + 1);
	localparam int MAG_W = DELTA_W + CPT_W;

	egpec_cmd_t cmd;
	egpec_sts_t sts;

	egpec_ctrl #(
		.DIV_STEPS(MAG_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	egpec_dp #(
		.COUNTS_PER_TURN(COUNTS_PER_TURN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

endmodule

/* hw/rtl/egpec_checker.sv */
// Port-level checks for the electronic gear position error counter, bound to the top.
// Depends on egpec_pkg for the port widths.
module egpec_checker
	import egpec_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only one tick is in work at a time.
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while a tick is in work");

	// A new result appears exactly as the block returns to idle.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result shown while still busy");

	// The saturation flag only comes with an error at one of the bounds.
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[49] |->
			m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000)
		else $error("saturation flag without a bound value");

	// Accepted request data is always known.
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown(s_tdata))
		else $error("request data unknown");

endmodule

bind electronic_gear_position_error_counter egpec_checker u_egpec_checker (.*);
